FILE: rtl/scmt_pkg.sv
// shared types, timing constants and status helper for the scanline mode timer
package scmt_pkg;

	localparam int unsigned CYCLES_W = 8;
	localparam int unsigned DOT_W    = 10;
	localparam int unsigned LINE_W   = 8;
	localparam int unsigned MASK_W   = 4;
	localparam int unsigned OUT_W    = 24;

	localparam logic [DOT_W-1:0]  OAM_CYCLES    = 10'd80;
	localparam logic [DOT_W-1:0]  DRAW_CYCLES   = 10'd172;
	localparam logic [DOT_W-1:0]  HBLANK_CYCLES = 10'd204;
	localparam logic [DOT_W-1:0]  LINE_CYCLES   = 10'd456;
	localparam logic [LINE_W-1:0] VBLANK_LINE   = 8'd144;
	localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;
	localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

	// mask bit positions
	localparam int unsigned SRC_HBLANK = 0;
	localparam int unsigned SRC_VBLANK = 1;
	localparam int unsigned SRC_OAM    = 2;
	localparam int unsigned SRC_COINC  = 3;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DISPLAY_ENABLE = 2'd0,
		REG_COMPARE_LINE   = 2'd1,
		REG_STAT_MASK      = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [DOT_W-1:0]  dot;
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              irq_level;
	} timer_state_t;

	typedef struct packed {
		logic              display_enable;
		logic [LINE_W-1:0] compare_line;
		logic [MASK_W-1:0] stat_mask;
	} timer_cfg_t;

	// result fields, first field in the highest bits
	typedef struct packed {
		logic              frame_done;
		logic              oam_scan_start;
		logic              line_render;
		logic              vblank_irq;
		logic              stat_irq;
		logic [7:0]        status_byte;
		logic              coincidence;
		logic [LINE_W-1:0] line;
		mode_t             mode;
	} timer_result_t;

	// status interrupt condition for a given mode and line
	function automatic logic stat_level(mode_t mode, logic [LINE_W-1:0] line,
			timer_cfg_t cfg);
		logic lvl;
		lvl = (line == cfg.compare_line) && cfg.stat_mask[SRC_COINC];
		lvl = lvl || ((mode == MODE_HBLANK) && cfg.stat_mask[SRC_HBLANK]);
		lvl = lvl || ((mode == MODE_VBLANK) && cfg.stat_mask[SRC_VBLANK]);
		lvl = lvl || ((mode == MODE_OAM) && cfg.stat_mask[SRC_OAM]);
		return lvl;
	endfunction

endpackage

FILE: rtl/scanline_mode_timer_stat_irq.sv
// top level of the scanline mode timer with status interrupt
// Each input transfer carries a count of elapsed machine cycles. The block adds it to
// the dot counter and walks the display through oam scan (80 dots), drawing (172),
// hblank (204) and vblank lines (456 each), lines 0 to 153 with vblank from line 144;
// several mode changes can happen in one step. Each step gives exactly one result
// transfer holding the new mode and line, the line coincidence, the status byte and
// the event flags. A step is captured in an input register and resolved by one pass
// of the step logic, which also updates the timing state; the result waits in an
// output register. Throughput is one step per clock while the result side is not
// stalling: the timing state loop closes through the step logic and the state
// register, so back-to-back steps see each other's effect. The result passes the
// input register and then the output register before its transfer. Configuration
// writes (index 0 display enable, 1 compare line, 2 source mask, 3 ignored) take
// effect at once and are meant to be made only while no step is in flight.
module scanline_mode_timer_stat_irq import scmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] cycles
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// [1:0] mode, [9:2] line, [10] coincidence, [18:11] status_byte, [19] stat_irq,
	// [20] vblank_irq, [21] line_render, [22] oam_scan_start, [23] frame_done
	output logic [OUT_W-1:0]    m_tdata,
	// configuration write port
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata
);

	// configuration registers
	timer_cfg_t cfg_q;

	// timing state: dot counter, mode, line, status line level
	timer_state_t state_q;
	timer_state_t state_nxt;

	// input stage
	logic                valid_s1;
	logic [CYCLES_W-1:0] cycles_s1;

	// output stage
	logic          m_valid_q;
	timer_result_t result_q;
	timer_result_t result_nxt;

	logic advance;

	// the input stage moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_enable <= 1'b1;
			cfg_q.compare_line   <= '0;
			cfg_q.stat_mask      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISPLAY_ENABLE: cfg_q.display_enable <= cfg_wdata[0];
				REG_COMPARE_LINE:   cfg_q.compare_line   <= cfg_wdata[LINE_W-1:0];
				REG_STAT_MASK:      cfg_q.stat_mask      <= cfg_wdata[MASK_W-1:0];
				default:            ; // unused index, write dropped
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cycles_s1 <= s_tdata[CYCLES_W-1:0];
		end
	end

	scmt_step u_step (
		.cycles (cycles_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.res    (result_nxt)
	);

	// timing state commits once per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.dot       <= '0;
			state_q.mode      <= MODE_OAM;
			state_q.line      <= '0;
			state_q.irq_level <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = result_q;

endmodule

FILE: rtl/scmt_step.sv
// next-state and result logic for one timing step
module scmt_step import scmt_pkg::*; (
	input  logic [CYCLES_W-1:0] cycles,
	input  timer_state_t        cur,
	input  timer_cfg_t          cfg,
	output timer_state_t        nxt,
	output timer_result_t       res
);

	always_comb begin
		logic [DOT_W-1:0]  dot;
		mode_t             mode;
		logic [LINE_W-1:0] line;
		logic              lvl;
		logic              lvl_new;
		logic              rose;
		logic              coinc;

		dot     = cur.dot + {{(DOT_W-CYCLES_W){1'b0}}, cycles};
		mode    = cur.mode;
		line    = cur.line;
		lvl     = cur.irq_level;
		lvl_new = 1'b0;
		rose    = 1'b0;
		res     = '0;

		// oam scan done
		if (mode == MODE_OAM && dot >= OAM_CYCLES) begin
			mode    = MODE_DRAW;
			dot     = dot - OAM_CYCLES;
			lvl_new = stat_level(mode, line, cfg);
			rose    = rose | (lvl_new & ~lvl);
			lvl     = lvl_new;
		end

		// drawing done; display off restarts timing at line 0
		if (mode == MODE_DRAW && dot >= DRAW_CYCLES) begin
			mode = MODE_HBLANK;
			dot  = dot - DRAW_CYCLES;
			if (!cfg.display_enable) begin
				dot  = '0;
				line = '0;
			end else begin
				res.line_render = 1'b1;
			end
			lvl_new = stat_level(mode, line, cfg);
			rose    = rose | (lvl_new & ~lvl);
			lvl     = lvl_new;
		end

		// hblank done, next line
		if (mode == MODE_HBLANK && dot >= HBLANK_CYCLES) begin
			dot  = dot - HBLANK_CYCLES;
			line = line + 8'd1;
			if (line == VBLANK_LINE) begin
				mode           = MODE_VBLANK;
				res.vblank_irq = 1'b1;
			end else begin
				mode               = MODE_OAM;
				res.oam_scan_start = 1'b1;
			end
			lvl_new = stat_level(mode, line, cfg);
			rose    = rose | (lvl_new & ~lvl);
			lvl     = lvl_new;
		end

		// vblank line done, surplus dots dropped
		if (mode == MODE_VBLANK && dot >= LINE_CYCLES) begin
			dot  = '0;
			line = line + 8'd1;
			if (line == TOTAL_LINES) begin
				line               = '0;
				mode               = MODE_OAM;
				res.oam_scan_start = 1'b1;
				res.frame_done     = 1'b1;
			end
			lvl_new = stat_level(mode, line, cfg);
			rose    = rose | (lvl_new & ~lvl);
			lvl     = lvl_new;
		end

		coinc           = (line == cfg.compare_line);
		res.mode        = mode;
		res.line        = line;
		res.coincidence = coinc;
		res.status_byte = {1'b1, cfg.stat_mask, coinc, mode};
		res.stat_irq    = rose;

		nxt.dot       = dot;
		nxt.mode      = mode;
		nxt.line      = line;
		nxt.irq_level = lvl;
	end

endmodule

FILE: rtl/scmt_checker.sv
// port-level checks for the scanline mode timer, bound to the top level
module scmt_checker import scmt_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// status byte agrees with mode and coincidence fields
	a_status_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[18] && (m_tdata[12:11] == m_tdata[1:0])
			&& (m_tdata[13] == m_tdata[10]))
		else $error("status byte inconsistent with mode or coincidence");

	// vblank entry leaves the block in vblank on line 144
	a_vblank_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> (m_tdata[1:0] == MODE_VBLANK)
			&& (m_tdata[9:2] == VBLANK_LINE))
		else $error("vblank flag without vblank on line 144");

	// frame wrap lands on line 0 in oam scan
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> (m_tdata[1:0] == MODE_OAM) && (m_tdata[9:2] == '0)
			&& m_tdata[22])
		else $error("frame done without return to line 0 oam scan");

	// line stays within the frame
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:2] <= LAST_LINE)
		else $error("line beyond last line");

endmodule

bind scanline_mode_timer_stat_irq scmt_checker u_scmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the scanline mode timer with status interrupt
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import scmt_pkg::*;

	// mode timing in dots, kept apart from the package values on purpose
	localparam logic [9:0] DOTS_OAM    = 10'd80;
	localparam logic [9:0] DOTS_DRAW   = 10'd172;
	localparam logic [9:0] DOTS_HBLANK = 10'd204;
	localparam logic [9:0] DOTS_LINE   = 10'd456;
	localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [7:0] LINES_PER_FRAME   = 8'd154;

	// index past the register list, writes there are dropped
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam int STALL_LIMIT    = 400;  // cycles with no transfer at all
	localparam int DRAIN_CYCLES   = 8;    // drain margin after the last expected result
	localparam int RANDOM_PHASES  = 8;
	localparam int REPORT_LIMIT   = 10;

	typedef enum logic {ROW_STEP, ROW_CFG} row_kind_t;

	// one row of the opening sequence; a step row either carries a typed-in
	// result or leaves it to the timing model
	typedef struct {
		row_kind_t  kind;
		logic [1:0] idx;
		logic [7:0] val;
		bit         typed;
		mode_t      mode;
		logic [7:0] line;
		logic [7:0] status;
		logic [4:0] flags;  // {frame_done, oam_scan_start, line_render, vblank_irq, stat_irq}
	} opening_row_t;

	localparam int OPENING_ROWS = 27;

	opening_row_t opening_plan [OPENING_ROWS] = '{
		// right after reset: oam scan, line 0 matches compare 0, no sources enabled
		'{ROW_STEP, REG_NONE,           8'd0,   1'b1, MODE_OAM,    8'd0, 8'h86, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd80,  1'b1, MODE_DRAW,   8'd0, 8'h87, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd172, 1'b1, MODE_HBLANK, 8'd0, 8'h84, 5'b00100},
		'{ROW_STEP, REG_NONE,           8'd204, 1'b1, MODE_OAM,    8'd1, 8'h82, 5'b01000},
		// all sources on, compare the current line
		'{ROW_CFG,  REG_STAT_MASK,      8'd15,  1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_CFG,  REG_COMPARE_LINE,   8'd1,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		// no transition: irq stays quiet, status shows the new registers
		'{ROW_STEP, REG_NONE,           8'd0,   1'b1, MODE_OAM,    8'd1, 8'hfe, 5'b00000},
		// two transitions in one step
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		// display off: the end of drawing drops back to line 0
		'{ROW_CFG,  REG_DISPLAY_ENABLE, 8'd0,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		// write past the register list must change nothing
		'{ROW_CFG,  REG_NONE,           8'hff,  1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_CFG,  REG_DISPLAY_ENABLE, 8'd1,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_CFG,  REG_COMPARE_LINE,   8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd1,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd128, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'h55,  1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'haa,  1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		// oam scan source alone
		'{ROW_CFG,  REG_COMPARE_LINE,   8'd0,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_CFG,  REG_STAT_MASK,      8'd4,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd255, 1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000},
		'{ROW_STEP, REG_NONE,           8'd0,   1'b0, MODE_HBLANK, 8'd0, 8'h00, 5'b00000}
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;    // [7:0] cycles
	logic              m_tvalid;
	logic              m_tready;
	// [1:0] mode, [9:2] line, [10] coincidence, [18:11] status_byte, [19] stat_irq,
	// [20] vblank_irq, [21] line_render, [22] oam_scan_start, [23] frame_done
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [7:0]        cfg_wdata;

	// timing model state and its copy of the registers
	logic [9:0]        dot_cnt;
	mode_t             cur_mode;
	logic [7:0]        cur_line;
	logic              irq_level;
	logic              disp_on;
	logic [7:0]        cmp_line;
	logic [3:0]        src_mask;

	timer_result_t     results_due [$];

	// idle behavior of each side, redrawn per phase
	bit                tx_calm;
	bit                rx_calm;

	int                mismatches;
	int                results_seen;
	int                steps_sent;
	int                cfg_writes;
	int                frames_seen;
	int                vblanks_seen;
	int                stat_irqs_seen;
	int                renders_seen;
	int                stall_run;
	timer_result_t     got_res;
	timer_result_t     want_res;

	scanline_mode_timer_stat_irq i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// status condition after a transition; true when it rises
	function automatic logic stat_rises();
		logic lvl;
		logic rose;
		lvl = ((cur_line == cmp_line) && src_mask[SRC_COINC])
			|| ((cur_mode == MODE_HBLANK) && src_mask[SRC_HBLANK])
			|| ((cur_mode == MODE_VBLANK) && src_mask[SRC_VBLANK])
			|| ((cur_mode == MODE_OAM) && src_mask[SRC_OAM]);
		rose = lvl && !irq_level;
		irq_level = lvl;
		return rose;
	endfunction

	// add elapsed cycles and run the four mode checks in their fixed order
	function automatic timer_result_t advance_timing(logic [7:0] cyc);
		timer_result_t r;
		r = '0;
		dot_cnt = dot_cnt + {2'b00, cyc};
		if (cur_mode == MODE_OAM && dot_cnt >= DOTS_OAM) begin
			cur_mode = MODE_DRAW;
			dot_cnt = dot_cnt - DOTS_OAM;
			r.stat_irq |= stat_rises();
		end
		if (cur_mode == MODE_DRAW && dot_cnt >= DOTS_DRAW) begin
			cur_mode = MODE_HBLANK;
			dot_cnt = dot_cnt - DOTS_DRAW;
			// display off restarts the frame instead of rendering
			if (!disp_on) begin
				dot_cnt = '0;
				cur_line = '0;
			end else begin
				r.line_render = 1'b1;
			end
			r.stat_irq |= stat_rises();
		end
		if (cur_mode == MODE_HBLANK && dot_cnt >= DOTS_HBLANK) begin
			dot_cnt = dot_cnt - DOTS_HBLANK;
			cur_line = cur_line + 8'd1;
			if (cur_line == FIRST_VBLANK_LINE) begin
				cur_mode = MODE_VBLANK;
				r.vblank_irq = 1'b1;
			end else begin
				cur_mode = MODE_OAM;
				r.oam_scan_start = 1'b1;
			end
			r.stat_irq |= stat_rises();
		end
		if (cur_mode == MODE_VBLANK && dot_cnt >= DOTS_LINE) begin
			// surplus dots are dropped at the end of a vblank line
			dot_cnt = '0;
			cur_line = cur_line + 8'd1;
			if (cur_line == LINES_PER_FRAME) begin
				cur_line = '0;
				cur_mode = MODE_OAM;
				r.oam_scan_start = 1'b1;
				r.frame_done = 1'b1;
			end
			r.stat_irq |= stat_rises();
		end
		r.mode = cur_mode;
		r.line = cur_line;
		r.coincidence = (cur_line == cmp_line);
		r.status_byte = {1'b1, src_mask, r.coincidence, cur_mode};
		return r;
	endfunction

	// one input transfer, with the model run at the accepting edge
	task automatic send_cycles(input logic [7:0] cyc, input bit typed,
			input timer_result_t typed_want);
		int unsigned gap;
		timer_result_t pred;
		gap = tx_calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = cyc;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = advance_timing(cyc);
		if (typed)
			pred = typed_want;
		results_due = {results_due, pred};
		steps_sent++;
		@(negedge clk);
	endtask

	// register write once every step in flight has come back
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		s_tvalid = 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_DISPLAY_ENABLE: disp_on  = val[0];
			REG_COMPARE_LINE:   cmp_line = val;
			REG_STAT_MASK:      src_mask = val[3:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic tally_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch in %s of result %0d: expected %0d, got %0d",
					what, results_seen, want, got);
		end
	endtask

	// result side: ready drops for a drawn number of cycles per transfer
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			int unsigned hold;
			hold = rx_calm ? 0 : $urandom_range(0, 16);
			if (hold != 0) begin
				m_tready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = timer_result_t'(m_tdata);
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result transfer %0d: data %h", results_seen, m_tdata);
			end else begin
				want_res = results_due.pop_front();
				tally_field("mode", want_res.mode, got_res.mode);
				tally_field("line", want_res.line, got_res.line);
				tally_field("coincidence", want_res.coincidence, got_res.coincidence);
				tally_field("status_byte", want_res.status_byte, got_res.status_byte);
				tally_field("stat_irq", want_res.stat_irq, got_res.stat_irq);
				tally_field("vblank_irq", want_res.vblank_irq, got_res.vblank_irq);
				tally_field("line_render", want_res.line_render, got_res.line_render);
				tally_field("oam_scan_start", want_res.oam_scan_start, got_res.oam_scan_start);
				tally_field("frame_done", want_res.frame_done, got_res.frame_done);
			end
			frames_seen    += got_res.frame_done;
			vblanks_seen   += got_res.vblank_irq;
			stat_irqs_seen += got_res.stat_irq;
			renders_seen   += got_res.line_render;
			results_seen++;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_run = 0;
		end else begin
			stall_run++;
			if (stall_run >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results still due",
					stall_run, results_due.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_DISPLAY_ENABLE;
		cfg_wdata = '0;
		tx_calm   = 1'b0;
		rx_calm   = 1'b0;
		mismatches = 0;
		results_seen = 0;
		steps_sent = 0;
		cfg_writes = 0;
		frames_seen = 0;
		vblanks_seen = 0;
		stat_irqs_seen = 0;
		renders_seen = 0;
		stall_run = 0;
		// state after reset
		dot_cnt   = '0;
		cur_mode  = MODE_OAM;
		cur_line  = '0;
		irq_level = 1'b0;
		disp_on   = 1'b1;
		cmp_line  = '0;
		src_mask  = '0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// opening sequence from the plan table
		for (int i = 0; i < OPENING_ROWS; i++) begin
			if (opening_plan[i].kind == ROW_CFG)
				write_reg(opening_plan[i].idx, opening_plan[i].val);
			else
				send_cycles(opening_plan[i].val, opening_plan[i].typed,
					timer_result_t'({opening_plan[i].flags, opening_plan[i].status,
						opening_plan[i].status[2], opening_plan[i].line,
						opening_plan[i].mode}));
		end

		// random phases, each under its own register setting
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			logic [7:0] cmp_pick;
			logic [3:0] mask_pick;
			int         n_steps;
			case (p)
				0:       cmp_pick = 8'd0;
				1:       cmp_pick = 8'd153;
				2:       cmp_pick = 8'd255;
				3:       cmp_pick = FIRST_VBLANK_LINE;
				default: cmp_pick = 8'($urandom_range(0, 255));
			endcase
			mask_pick = (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom_range(0, 15));
			// upper bits of the write data are junk the block must ignore
			write_reg(REG_DISPLAY_ENABLE,
				{7'($urandom_range(0, 127)), (p == 3 || p == 6) ? 1'b0 : 1'b1});
			write_reg(REG_COMPARE_LINE, cmp_pick);
			write_reg(REG_STAT_MASK, {4'($urandom_range(0, 15)), mask_pick});
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// the first phase leans on large counts so a whole frame goes by
			n_steps = (p == 0) ? 430 : 145;
			for (int k = 0; k < n_steps; k++) begin
				int unsigned sel;
				logic [7:0]  cyc;
				sel = $urandom_range(0, 99);
				if (p == 0)
					cyc = (sel < 25) ? 8'd255 :
						(sel < 85) ? 8'($urandom_range(160, 255)) : 8'($urandom_range(0, 255));
				else
					cyc = (sel < 8) ? 8'd0 : (sel < 16) ? 8'd255 :
						(sel < 36) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
				send_cycles(cyc, 1'b0, '0);
			end
		end

		s_tvalid = 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("%0d timing steps over %0d register writes, %0d results checked",
			steps_sent, cfg_writes, results_seen);
		$display("%0d frames, %0d vblank entries, %0d rendered lines, %0d status irqs, %0d mismatches",
			frames_seen, vblanks_seen, renders_seen, stat_irqs_seen, mismatches);
		if (mismatches == 0 && results_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
